// ----- src/bfsp_pkg.sv -----
// ----------------------------------------------------------------------------
// bfsp_pkg
// Shared types and constants for the shortest path engine: table sizes,
// record layouts of the edge and vertex memories, codes and sequencer states.
// ----------------------------------------------------------------------------
package bfsp_pkg;

	localparam int MAX_V = 64;
	localparam int MAX_E = 256;
	localparam int VID_W = $clog2(MAX_V);
	localparam int VCNT_W = $clog2(MAX_V + 1);
	localparam int EID_W = $clog2(MAX_E);
	localparam int ECNT_W = $clog2(MAX_E + 1);
	localparam int W_W = 16;
	localparam int D_W = 32;

	// Input operation codes.
	localparam logic OP_ADD = 1'b0;
	localparam logic OP_RUN = 1'b1;

	// Result kinds.
	localparam logic KIND_ACK = 1'b0;
	localparam logic KIND_ROW = 1'b1;

	// One stored edge.
	typedef struct packed {
		logic [VID_W-1:0] a;
		logic [VID_W-1:0] b;
		logic signed [W_W-1:0] w;
	} edge_rec_t;

	// Per-vertex working state.
	typedef struct packed {
		logic signed [D_W-1:0] dist_val;
		logic reached;
		logic [VID_W-1:0] pred;
		logic pred_ok;
	} vtx_rec_t;

	// Sequencer states, one-hot.
	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_CLR   = 11'b00000000010,
		S_START = 11'b00000000100,
		S_EREAD = 11'b00000001000,
		S_CHK   = 11'b00000010000,
		S_SRD   = 11'b00000100000,
		S_DRD   = 11'b00001000000,
		S_CALC  = 11'b00010000000,
		S_NEXT  = 11'b00100000000,
		S_ORD   = 11'b01000000000,
		S_OLD   = 11'b10000000000
	} state_t;

endpackage

// ----- src/bellman_ford_shortest_path_top.sv -----
// ----------------------------------------------------------------------------
// bellman_ford_shortest_path_top
// An add or a rejected run is acknowledged in the cycle after it is taken.
// A run clears all 64 vertex records, writes the start vertex, then makes
// vertex_count+1 passes over every vertex and its edges, the last of them a
// check pass that writes nothing; then it puts out one row per vertex.
// One item at a time. Reset empties the edge table and sets vertex_count to 64.
// ----------------------------------------------------------------------------
module bellman_ford_shortest_path_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [5:0]  vertex_a,
	input  logic [5:0]  vertex_b,
	input  logic signed [15:0] weight,
	input  logic [5:0]  start_vertex,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic        accepted,
	output logic [5:0]  vertex_index,
	output logic signed [31:0] distance,
	output logic        reachable,
	output logic        has_predecessor,
	output logic [5:0]  predecessor,
	output logic        no_negative_cycle,
	output logic        last
);

	localparam int VID_W = bfsp_pkg::VID_W;
	localparam int VCNT_W = bfsp_pkg::VCNT_W;
	localparam int EID_W = bfsp_pkg::EID_W;
	localparam int ECNT_W = bfsp_pkg::ECNT_W;
	localparam int D_W = bfsp_pkg::D_W;
	localparam int W_W = bfsp_pkg::W_W;

	bfsp_pkg::state_t state_q;
	logic [VCNT_W-1:0] vc_q;
	logic [ECNT_W-1:0] ec_q;
	logic [VID_W-1:0] v_q;
	logic [EID_W-1:0] e_q;
	logic [VCNT_W-1:0] pass_q;
	logic [VID_W-1:0] clr_q;
	logic [VID_W-1:0] start_q;
	logic [VID_W-1:0] dst_q;
	logic side_q;
	logic improved_q;
	bfsp_pkg::vtx_rec_t src_q;

	logic out_valid_q;
	logic kind_q, accepted_q, reachable_q, has_pred_q, clean_q, last_q;
	logic [VID_W-1:0] vidx_q, pred_q;
	logic signed [D_W-1:0] dist_q;

	// Memory ports.
	logic e_we;
	bfsp_pkg::edge_rec_t e_wrec, e_rd;
	logic [$bits(bfsp_pkg::edge_rec_t)-1:0] e_rdata;
	logic v_we;
	logic [VID_W-1:0] v_waddr, v_raddr;
	bfsp_pkg::vtx_rec_t v_wrec, v_rd;
	logic [$bits(bfsp_pkg::vtx_rec_t)-1:0] v_rdata;

	// Handshake and decode.
	logic out_free, in_take, cfg_take, commit;
	logic add_ok, run_ok;
	logic signed [D_W:0] sum;
	logic signed [D_W-1:0] alt;
	logic improves;
	logic e_more, v_more, row_last;

	// A pending register write holds off new requests so the two never meet.
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == bfsp_pkg::S_IDLE) && out_free && !cfg_valid);
	assign in_take = in_valid && !in_stall;
	assign cfg_ready = (state_q == bfsp_pkg::S_IDLE);
	assign cfg_take = cfg_valid && cfg_ready;
	assign commit = (pass_q != vc_q);

	assign add_ok = (ec_q < ECNT_W'(bfsp_pkg::MAX_E)) && ({1'b0, vertex_a} < vc_q)
		&& ({1'b0, vertex_b} < vc_q);
	assign run_ok = ({1'b0, start_vertex} < vc_q);

	assign e_rd = bfsp_pkg::edge_rec_t'(e_rdata);
	assign v_rd = bfsp_pkg::vtx_rec_t'(v_rdata);

	// Saturating candidate distance and improvement test.
	assign sum = {src_q.dist_val[D_W-1], src_q.dist_val}
		+ {{(D_W+1-W_W){e_rd.w[W_W-1]}}, e_rd.w};
	always_comb begin
		if (sum[D_W] != sum[D_W-1]) begin
			alt = sum[D_W] ? {1'b1, {(D_W-1){1'b0}}} : {1'b0, {(D_W-1){1'b1}}};
		end else begin
			alt = sum[D_W-1:0];
		end
	end
	assign improves = src_q.reached && (!v_rd.reached || (alt < v_rd.dist_val));

	assign e_more = (({1'b0, e_q} + ECNT_W'(1)) < ec_q);
	assign v_more = (({1'b0, v_q} + VCNT_W'(1)) < vc_q);
	assign row_last = !v_more;

	// Edge memory write on an accepted add.
	assign e_we = in_take && (op == bfsp_pkg::OP_ADD) && add_ok;
	assign e_wrec = '{a: vertex_a, b: vertex_b, w: weight};

	bfsp_ram #(
		.WIDTH($bits(bfsp_pkg::edge_rec_t)),
		.DEPTH(bfsp_pkg::MAX_E)
	) u_edge_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (ec_q[EID_W-1:0]),
		.wdata (e_wrec),
		.raddr (e_q),
		.rdata (e_rdata)
	);

	// Vertex memory port selection.
	always_comb begin
		v_we = 1'b0;
		v_waddr = dst_q;
		v_wrec = '0;
		v_raddr = v_q;
		case (state_q)
			bfsp_pkg::S_CLR: begin
				v_we = 1'b1;
				v_waddr = clr_q;
			end
			bfsp_pkg::S_START: begin
				v_we = 1'b1;
				v_waddr = start_q;
				v_wrec.reached = 1'b1;
			end
			bfsp_pkg::S_DRD: begin
				v_raddr = dst_q;
			end
			bfsp_pkg::S_CALC: begin
				v_raddr = dst_q;
				v_we = commit && improves;
				v_wrec = '{dist_val: alt, reached: 1'b1, pred: v_q, pred_ok: 1'b1};
			end
			default: begin
				v_raddr = v_q;
			end
		endcase
	end

	bfsp_ram #(
		.WIDTH($bits(bfsp_pkg::vtx_rec_t)),
		.DEPTH(bfsp_pkg::MAX_V)
	) u_vtx_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wrec),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	// Sequencer: clear, relaxation passes, check pass, row output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfsp_pkg::S_IDLE;
			vc_q <= VCNT_W'(bfsp_pkg::MAX_V);
			ec_q <= '0;
			v_q <= '0;
			e_q <= '0;
			pass_q <= '0;
			clr_q <= '0;
			dst_q <= '0;
			side_q <= 1'b0;
			improved_q <= 1'b0;
		end else begin
			case (state_q)
				bfsp_pkg::S_IDLE: begin
					if (cfg_take) begin
						vc_q <= (cfg_data > 7'(bfsp_pkg::MAX_V)) ? VCNT_W'(bfsp_pkg::MAX_V)
							: VCNT_W'(cfg_data);
						ec_q <= '0;
					end else if (in_take) begin
						if (op == bfsp_pkg::OP_ADD) begin
							if (add_ok) begin
								ec_q <= ec_q + ECNT_W'(1);
							end
						end else if (run_ok) begin
							clr_q <= '0;
							v_q <= '0;
							e_q <= '0;
							pass_q <= '0;
							improved_q <= 1'b0;
							state_q <= bfsp_pkg::S_CLR;
						end
					end
				end
				bfsp_pkg::S_CLR: begin
					clr_q <= clr_q + VID_W'(1);
					if (clr_q == VID_W'(bfsp_pkg::MAX_V - 1)) begin
						state_q <= bfsp_pkg::S_START;
					end
				end
				bfsp_pkg::S_START: begin
					state_q <= bfsp_pkg::S_EREAD;
				end
				bfsp_pkg::S_EREAD: begin
					side_q <= 1'b0;
					state_q <= (ec_q == '0) ? bfsp_pkg::S_NEXT : bfsp_pkg::S_CHK;
				end
				bfsp_pkg::S_CHK: begin
					if (!side_q) begin
						if (e_rd.a == v_q) begin
							dst_q <= e_rd.b;
							state_q <= bfsp_pkg::S_SRD;
						end else begin
							side_q <= 1'b1;
						end
					end else if (e_rd.b == v_q) begin
						dst_q <= e_rd.a;
						state_q <= bfsp_pkg::S_SRD;
					end else begin
						state_q <= bfsp_pkg::S_NEXT;
					end
				end
				bfsp_pkg::S_SRD: begin
					state_q <= bfsp_pkg::S_DRD;
				end
				bfsp_pkg::S_DRD: begin
					state_q <= bfsp_pkg::S_CALC;
				end
				bfsp_pkg::S_CALC: begin
					if (!commit && improves) begin
						improved_q <= 1'b1;
					end
					if (!side_q) begin
						side_q <= 1'b1;
						state_q <= bfsp_pkg::S_CHK;
					end else begin
						state_q <= bfsp_pkg::S_NEXT;
					end
				end
				bfsp_pkg::S_NEXT: begin
					if (e_more) begin
						e_q <= e_q + EID_W'(1);
						state_q <= bfsp_pkg::S_EREAD;
					end else begin
						e_q <= '0;
						if (v_more) begin
							v_q <= v_q + VID_W'(1);
							state_q <= bfsp_pkg::S_EREAD;
						end else begin
							v_q <= '0;
							if (!commit) begin
								state_q <= bfsp_pkg::S_ORD;
							end else begin
								pass_q <= pass_q + VCNT_W'(1);
								state_q <= bfsp_pkg::S_EREAD;
							end
						end
					end
				end
				bfsp_pkg::S_ORD: begin
					state_q <= bfsp_pkg::S_OLD;
				end
				bfsp_pkg::S_OLD: begin
					if (out_free) begin
						if (row_last) begin
							state_q <= bfsp_pkg::S_IDLE;
						end else begin
							v_q <= v_q + VID_W'(1);
							state_q <= bfsp_pkg::S_ORD;
						end
					end
				end
				default: begin
					state_q <= bfsp_pkg::S_IDLE;
				end
			endcase
		end
	end

	// Source record capture and run start vertex.
	always_ff @(posedge clk) begin
		if (state_q == bfsp_pkg::S_DRD) begin
			src_q <= v_rd;
		end
		if (in_take) begin
			start_q <= start_vertex;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_take && !(op == bfsp_pkg::OP_RUN && run_ok)) begin
			out_valid_q <= 1'b1;
		end else if (state_q == bfsp_pkg::S_OLD && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload: acknowledges and vertex rows.
	always_ff @(posedge clk) begin
		if (in_take && !(op == bfsp_pkg::OP_RUN && run_ok)) begin
			kind_q <= bfsp_pkg::KIND_ACK;
			accepted_q <= (op == bfsp_pkg::OP_ADD) && add_ok;
			vidx_q <= '0;
			dist_q <= '0;
			reachable_q <= 1'b0;
			has_pred_q <= 1'b0;
			pred_q <= '0;
			clean_q <= 1'b0;
			last_q <= 1'b1;
		end else if (state_q == bfsp_pkg::S_OLD && out_free) begin
			kind_q <= bfsp_pkg::KIND_ROW;
			accepted_q <= 1'b1;
			vidx_q <= v_q;
			dist_q <= v_rd.reached ? v_rd.dist_val : '0;
			reachable_q <= v_rd.reached;
			has_pred_q <= v_rd.pred_ok;
			pred_q <= v_rd.pred_ok ? v_rd.pred : '0;
			clean_q <= !improved_q;
			last_q <= row_last;
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign accepted = accepted_q;
	assign vertex_index = vidx_q;
	assign distance = dist_q;
	assign reachable = reachable_q;
	assign has_predecessor = has_pred_q;
	assign predecessor = pred_q;
	assign no_negative_cycle = clean_q;
	assign last = last_q;

	// The edge count never passes the table size.
	a_ec_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ec_q <= ECNT_W'(bfsp_pkg::MAX_E))
		else $error("edge count beyond table size");

	// The vertex being walked stays inside the configured graph during a run.
	a_v_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bfsp_pkg::S_CHK || state_q == bfsp_pkg::S_OLD) |-> ({1'b0, v_q} < vc_q))
		else $error("vertex index outside graph");

	// The check pass never writes the vertex memory.
	a_check_ro: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bfsp_pkg::S_CALC && !commit) |-> !v_we)
		else $error("vertex write during check pass");

	// A last row returns the sequencer to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bfsp_pkg::S_OLD && out_free && row_last) |=> state_q == bfsp_pkg::S_IDLE)
		else $error("run did not finish after last row");

endmodule

// ----- src/bfsp_ram.sv -----
// ----------------------------------------------------------------------------
// bfsp_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module bfsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shortest path engine testbench
// Drives add and run requests through the stall handshake, writes the vertex
// count between phases, and checks every result against a predictor that keeps
// its own edge table and distance state.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int LIMIT_CYCLES = 3000000;

	// One result as seen on the output port.
	typedef struct packed {
		logic kind;
		logic accepted;
		logic [5:0] vidx;
		logic signed [31:0] dist_val;
		logic reach;
		logic has_pred;
		logic [5:0] pred;
		logic no_neg;
		logic last;
	} path_row_t;

	typedef enum logic [1:0] {STEP_ITEM, STEP_CFG} step_kind_t;
	typedef enum logic [1:0] {ACK_PREDICT, ACK_YES, ACK_NO} ack_check_t;

	// One directed stimulus step: either a request or a vertex count write.
	typedef struct {
		step_kind_t sk;
		logic op_code;
		logic [5:0] va;
		logic [5:0] vb;
		logic signed [15:0] w;
		logic [5:0] sv;
		ack_check_t ack;
	} plan_step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [6:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic op = bfsp_pkg::OP_ADD;
	logic [5:0] vertex_a = '0;
	logic [5:0] vertex_b = '0;
	logic signed [15:0] weight = '0;
	logic [5:0] start_vertex = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic kind;
	logic accepted;
	logic [5:0] vertex_index;
	logic signed [31:0] distance;
	logic reachable;
	logic has_predecessor;
	logic [5:0] predecessor;
	logic no_negative_cycle;
	logic last;

	bellman_ford_shortest_path_top u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .op(op), .vertex_a(vertex_a),
		.vertex_b(vertex_b), .weight(weight), .start_vertex(start_vertex),
		.out_valid(out_valid), .out_stall(out_stall), .kind(kind),
		.accepted(accepted), .vertex_index(vertex_index), .distance(distance),
		.reachable(reachable), .has_predecessor(has_predecessor),
		.predecessor(predecessor), .no_negative_cycle(no_negative_cycle),
		.last(last)
	);

	always #10 clk = ~clk;

	// Predictor state: edge table, vertex count and per-vertex path state.
	logic [5:0] edge_from [bfsp_pkg::MAX_E];
	logic [5:0] edge_to [bfsp_pkg::MAX_E];
	logic signed [15:0] edge_weight [bfsp_pkg::MAX_E];
	int edge_total;
	int vertex_total;
	logic signed [31:0] best_dist [bfsp_pkg::MAX_V];
	bit reached [bfsp_pkg::MAX_V];
	logic [5:0] pred_of [bfsp_pkg::MAX_V];
	bit pred_known [bfsp_pkg::MAX_V];

	path_row_t expected_rows[$];
	path_row_t fresh_rows[$];
	int mismatches = 0;
	int cycle_count = 0;
	bit quiet = 1'b0;
	int hold_cycles = 0;
	int burst_left = 0;

	function automatic logic signed [31:0] clamp_sum(logic signed [31:0] d,
			logic signed [15:0] w);
		longint s;
		s = longint'(d) + longint'(w);
		if (s > 64'sd2147483647)
			return 32'sh7fffffff;
		if (s < -64'sd2147483648)
			return 32'sh80000000;
		return s[31:0];
	endfunction

	// Try to improve dst through src; returns whether it would improve.
	function automatic bit try_improve(int src, int dst, logic signed [15:0] w,
			bit commit);
		logic signed [31:0] alt;
		if (src >= vertex_total || dst >= vertex_total || !reached[src])
			return 1'b0;
		alt = clamp_sum(best_dist[src], w);
		if (reached[dst] && !(alt < best_dist[dst]))
			return 1'b0;
		if (commit) begin
			best_dist[dst] = alt;
			reached[dst] = 1'b1;
			pred_of[dst] = src[5:0];
			pred_known[dst] = 1'b1;
		end
		return 1'b1;
	endfunction

	// One pass over all vertices in order and their edges in insertion order.
	function automatic bit sweep_edges(bit commit);
		bit improved;
		improved = 1'b0;
		for (int v = 0; v < vertex_total; v++) begin
			for (int e = 0; e < edge_total; e++) begin
				if (edge_from[e] == v && try_improve(v, int'(edge_to[e]), edge_weight[e],
						commit))
					improved = 1'b1;
				if (edge_to[e] == v && try_improve(v, int'(edge_from[e]), edge_weight[e],
						commit))
					improved = 1'b1;
			end
		end
		return improved;
	endfunction

	function automatic path_row_t ack_row(bit ok);
		path_row_t r;
		r = '0;
		r.kind = bfsp_pkg::KIND_ACK;
		r.accepted = ok;
		r.last = 1'b1;
		return r;
	endfunction

	// Work out the results of one accepted request into fresh_rows.
	function automatic void predict_request(logic op_code, logic [5:0] va,
			logic [5:0] vb, logic signed [15:0] w, logic [5:0] sv);
		bit clean;
		path_row_t r;
		fresh_rows.delete();
		if (op_code == bfsp_pkg::OP_ADD) begin
			if (edge_total >= bfsp_pkg::MAX_E || va >= vertex_total
					|| vb >= vertex_total) begin
				fresh_rows.insert(fresh_rows.size(), ack_row(1'b0));
			end else begin
				edge_from[edge_total] = va;
				edge_to[edge_total] = vb;
				edge_weight[edge_total] = w;
				edge_total++;
				fresh_rows.insert(fresh_rows.size(), ack_row(1'b1));
			end
			return;
		end
		if (sv >= vertex_total) begin
			fresh_rows.insert(fresh_rows.size(), ack_row(1'b0));
			return;
		end
		for (int v = 0; v < bfsp_pkg::MAX_V; v++) begin
			best_dist[v] = '0;
			reached[v] = 1'b0;
			pred_of[v] = '0;
			pred_known[v] = 1'b0;
		end
		reached[sv] = 1'b1;
		for (int p = 0; p < vertex_total; p++)
			void'(sweep_edges(1'b1));
		clean = !sweep_edges(1'b0);
		for (int v = 0; v < vertex_total; v++) begin
			r.kind = bfsp_pkg::KIND_ROW;
			r.accepted = 1'b1;
			r.vidx = v[5:0];
			r.dist_val = reached[v] ? best_dist[v] : 32'sd0;
			r.reach = reached[v];
			r.has_pred = pred_known[v];
			r.pred = pred_known[v] ? pred_of[v] : 6'd0;
			r.no_neg = clean;
			r.last = (v + 1 == vertex_total);
			fresh_rows.insert(fresh_rows.size(), r);
		end
	endfunction

	// Offer one request; entered and left at a falling edge.
	task automatic send_request(logic op_code, logic [5:0] va, logic [5:0] vb,
			logic signed [15:0] w, logic [5:0] sv, ack_check_t ack);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		op <= op_code;
		vertex_a <= va;
		vertex_b <= vb;
		weight <= w;
		start_vertex <= sv;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_request(op_code, va, vb, w, sv);
		if (ack == ACK_PREDICT) begin
			foreach (fresh_rows[i])
				expected_rows.insert(expected_rows.size(), fresh_rows[i]);
		end else begin
			expected_rows.insert(expected_rows.size(), ack_row(ack == ACK_YES));
		end
		@(negedge clk);
	endtask

	// Let the block drain completely before a register write.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_rows.size() > 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_vertex_count(logic [6:0] value);
		wait_idle();
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		vertex_total = (value > bfsp_pkg::MAX_V) ? bfsp_pkg::MAX_V : int'(value);
		edge_total = 0;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Random request: mostly well-formed edges and runs inside the graph.
	task automatic send_random(int vc_hi, int run_pct);
		logic [5:0] va, vb, sv;
		logic signed [15:0] w;
		int lim;
		lim = (vc_hi > 0) ? vc_hi - 1 : 0;
		va = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
			: 6'($urandom_range(0, lim));
		vb = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
			: 6'($urandom_range(0, lim));
		sv = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
			: 6'($urandom_range(0, lim));
		if ($urandom_range(0, 3) == 0)
			w = 16'($urandom_range(0, 65535));
		else
			w = 16'($urandom_range(0, 300));
		send_request(($urandom_range(0, 99) < run_pct) ? bfsp_pkg::OP_RUN
			: bfsp_pkg::OP_ADD, va, vb, w, sv, ACK_PREDICT);
	endtask

	// Receiver: random stall bursts, plus a long hold when one is requested.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else if (burst_left > 0) begin
			burst_left <= burst_left - 1;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			burst_left <= $urandom_range(0, 4);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		path_row_t got;
		path_row_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{kind, accepted, vertex_index, distance, reachable, has_predecessor,
				predecessor, no_negative_cycle, last};
			if (expected_rows.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: %p", got);
			end else begin
				want = expected_rows[0];
				expected_rows.delete(0);
				if (got.kind !== want.kind || got.accepted !== want.accepted ||
						got.vidx !== want.vidx || got.dist_val !== want.dist_val ||
						got.reach !== want.reach || got.has_pred !== want.has_pred ||
						got.pred !== want.pred || got.no_neg !== want.no_neg ||
						got.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected %p, actual %p", want, got);
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	plan_step_t plan [23] = '{
		'{STEP_ITEM, bfsp_pkg::OP_ADD, 6'd0, 6'd1, 16'sd32767, 6'd0, ACK_YES},
		'{STEP_ITEM, bfsp_pkg::OP_ADD, 6'd1, 6'd2, -16'sd32768, 6'd0, ACK_YES},
		'{STEP_ITEM, bfsp_pkg::OP_ADD, 6'd63, 6'd63, -16'sd1, 6'd0, ACK_YES},
		'{STEP_ITEM, bfsp_pkg::OP_ADD, 6'd2, 6'd0, 16'sd0, 6'd0, ACK_YES},
		'{STEP_ITEM, bfsp_pkg::OP_RUN, 6'd0, 6'd0, 16'sd0, 6'd0, ACK_PREDICT},
		'{STEP_ITEM, bfsp_pkg::OP_RUN, 6'd63, 6'd63, -16'sd1, 6'd63, ACK_PREDICT},
		'{STEP_ITEM, bfsp_pkg::OP_RUN, 6'd0, 6'd0, 16'sd0, 6'd5, ACK_PREDICT},
		'{STEP_CFG, bfsp_pkg::OP_ADD, 6'd0, 6'd0, 16'sd127, 6'd0, ACK_PREDICT},
		'{STEP_ITEM, bfsp_pkg::OP_RUN, 6'd0, 6'd0, 16'sd0, 6'd63, ACK_PREDICT},
		'{STEP_CFG, bfsp_pkg::OP_ADD, 6'd0, 6'd0, 16'sd0, 6'd0, ACK_PREDICT},
		'{STEP_ITEM, bfsp_pkg::OP_ADD, 6'd0, 6'd0, 16'sd5, 6'd0, ACK_NO},
		'{STEP_ITEM, bfsp_pkg::OP_RUN, 6'd0, 6'd0, 16'sd0, 6'd0, ACK_NO},
		'{STEP_CFG, bfsp_pkg::OP_ADD, 6'd0, 6'd0, 16'sd3, 6'd0, ACK_PREDICT},
		'{STEP_ITEM, bfsp_pkg::OP_ADD, 6'd3, 6'd0, 16'sd1, 6'd0, ACK_NO},
		'{STEP_ITEM, bfsp_pkg::OP_ADD, 6'd0, 6'd3, 16'sd1, 6'd0, ACK_NO},
		'{STEP_ITEM, bfsp_pkg::OP_ADD, 6'd0, 6'd1, 16'sd100, 6'd0, ACK_YES},
		'{STEP_ITEM, bfsp_pkg::OP_ADD, 6'd1, 6'd2, 16'sd50, 6'd0, ACK_YES},
		'{STEP_ITEM, bfsp_pkg::OP_ADD, 6'd0, 6'd2, 16'sd200, 6'd0, ACK_YES},
		'{STEP_ITEM, bfsp_pkg::OP_RUN, 6'd0, 6'd0, 16'sd0, 6'd0, ACK_PREDICT},
		'{STEP_ITEM, bfsp_pkg::OP_RUN, 6'd0, 6'd0, 16'sd0, 6'd3, ACK_NO},
		'{STEP_ITEM, bfsp_pkg::OP_RUN, 6'd0, 6'd0, 16'sd0, 6'd2, ACK_PREDICT},
		'{STEP_ITEM, bfsp_pkg::OP_ADD, 6'd2, 6'd2, 16'sd7, 6'd0, ACK_YES},
		'{STEP_ITEM, bfsp_pkg::OP_RUN, 6'd0, 6'd0, 16'sd0, 6'd1, ACK_PREDICT}
	};

	initial begin
		int vc;
		edge_total = 0;
		vertex_total = bfsp_pkg::MAX_V;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, starting from the reset vertex count of 64.
		foreach (plan[i]) begin
			if (plan[i].sk == STEP_CFG)
				write_vertex_count(plan[i].w[6:0]);
			else
				send_request(plan[i].op_code, plan[i].va, plan[i].vb, plan[i].w,
					plan[i].sv, plan[i].ack);
		end

		// Random phases on small graphs; one short phase on the full graph.
		for (int ph = 0; ph < 9; ph++) begin
			vc = (ph == 4) ? 64 : $urandom_range(2, 8);
			if (ph == 8)
				quiet = 1'b1;
			write_vertex_count(vc[6:0]);
			if (ph == 2)
				hold_cycles = 200;
			for (int i = 0; i < ((ph == 4) ? 5 : 8); i++)
				send_random(vc, (ph == 4) ? 10 : 25);
			send_request(bfsp_pkg::OP_RUN, 6'd0, 6'd0, 16'sd0,
				6'($urandom_range(0, vc - 1)), ACK_PREDICT);
		end

		wait_idle();
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
src/bfsp_pkg.sv
src/bfsp_ram.sv
src/bellman_ford_shortest_path_top.sv
bench/tb_top.sv
